/* design/tcee_pkg.sv */
// Shared types and constants of the text console escape engine.
`timescale 1ns / 1ps

package tcee_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 2;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int VAL_W  = 10;

    localparam logic [VAL_W-1:0] NUM_CAP    = 10'd1000;
    localparam logic             FONT_RESET = 1'b1;

    localparam logic [7:0] CH_BEL  = 8'd7;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_SUB  = 8'd26;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_LAST_WS = 8'd13;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_DOLR = 8'h24;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_J    = 8'h4A;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_Z_LC = 8'h7A;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [1:0] KD_PLAIN = 2'd0;
    localparam logic [1:0] KD_CSI   = 2'd1;
    localparam logic [1:0] KD_TUNE  = 2'd2;

    localparam logic [ATTR_W-1:0] ATTR_NORMAL = 2'd0;
    localparam logic [ATTR_W-1:0] ATTR_ACCENT = 2'd1;

    typedef enum logic [3:0] {
        EV_NONE     = 4'd0,
        EV_CELL     = 4'd1,
        EV_CLEARED  = 4'd2,
        EV_ERASED   = 4'd3,
        EV_NEWLINE  = 4'd4,
        EV_CURSOR   = 4'd5,
        EV_BELL     = 4'd6,
        EV_MODE     = 4'd7,
        EV_TUNE     = 4'd8,
        EV_TUNE_END = 4'd9,
        EV_READ     = 4'd10
    } t_ev;

    typedef enum logic [3:0] {
        CLS_READ,
        CLS_FONT,
        CLS_CR,
        CLS_LF,
        CLS_BS,
        CLS_SUB,
        CLS_BEL,
        CLS_ESC,
        CLS_OTHER
    } t_cls;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_SEMI,
        ST_NUM
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_byte;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_item;

    typedef struct packed {
        t_ev               event_res;
        logic              scrolled;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_col_out;
        logic              narrow_font;
    } t_res;

    typedef struct packed {
        t_cls  cls;
        t_item item;
    } t_qent;

endpackage

/* design/tcee_front.sv */
// Front part: classifies incoming items and holds them in a two-entry queue.
`timescale 1ns / 1ps

module tcee_front import tcee_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_hold,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_entry,
    input  logic  i_take
);

    t_qent      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_cls       w_cls;

    always_comb begin
        if (i_item.kind) begin
            w_cls = CLS_READ;
        end else begin
            case (i_item.char_byte)
                CH_DEL:  w_cls = CLS_FONT;
                CH_CR:   w_cls = CLS_CR;
                CH_LF:   w_cls = CLS_LF;
                CH_BS:   w_cls = CLS_BS;
                CH_SUB:  w_cls = CLS_SUB;
                CH_BEL:  w_cls = CLS_BEL;
                CH_ESC:  w_cls = CLS_ESC;
                default: w_cls = CLS_OTHER;
            endcase
        end
    end

    assign o_full  = (r_cnt == 2'd2) || i_hold;
    assign w_push  = i_push && !o_full;
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{cls: w_cls, item: i_item};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_take);
        end
    end

endmodule

/* design/tcee_back.sv */
// Back part: escape state, cursor, cell memory, sweeps and the result register.
`timescale 1ns / 1ps

module tcee_back import tcee_pkg::*; #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 40,
    parameter int CSI_MAX  = 16,
    parameter int TUNE_MAX = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_qent i_q_entry,
    output logic  o_q_take,
    output logic  o_init,
    output logic  o_res_valid,
    output t_res  o_res,
    input  logic  i_pop
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CI_W  = $clog2(CSI_MAX);
    localparam int CL_W  = $clog2(CSI_MAX + 1);
    localparam int TL_W  = $clog2(TUNE_MAX + 1);

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_top, n_top, r_crow, n_crow;
    logic [COL_W-1:0]  r_ccol, n_ccol, r_pcol, n_pcol;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic [1:0]        r_phase, n_phase, r_kind, n_kind;
    logic [CL_W-1:0]   r_clen, n_clen, r_pi, n_pi;
    logic [TL_W-1:0]   r_tlen, n_tlen;
    logic              r_font, n_font;
    logic              r_ov, n_ov;
    t_res              r_out, n_out, r_pend, n_pend;
    logic [AW-1:0]     r_sw_addr, n_sw_addr, r_sw_last, n_sw_last;
    logic              r_sw_emit, n_sw_emit;
    logic              r_rd_ok, n_rd_ok;
    logic              r_pstage, n_pstage, r_neg, n_neg, r_ptgt, n_ptgt;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [CELL_W-1:0] r_rd;

    logic [CHAR_W-1:0] r_csi [CSI_MAX];
    logic [CELL_W-1:0] mem [DEPTH];

    logic              w_we, w_csi_we;
    logic [AW-1:0]     w_wa, w_ra;
    logic [CELL_W-1:0] w_wd;
    logic [AW-1:0]     w_cur_addr, w_row_end, w_top_base;
    logic [CHAR_W-1:0] w_cur;

    function automatic logic [AW-1:0] f_addr(input logic [ROW_W-1:0] row,
                                             input logic [COL_W-1:0] col,
                                             input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, row} + {1'b0, top};
        if (s >= (ROW_W+1)'(ROWS)) s = s - (ROW_W+1)'(ROWS);
        return AW'(int'(s) * COLUMNS + int'(col));
    endfunction

    // Converts a parsed number to a zero-based position clamped below lim.
    function automatic logic [COL_W-1:0] f_pos(input logic neg, input logic [VAL_W-1:0] val,
                                               input logic [COL_W:0] lim);
        logic [VAL_W-1:0] v;
        v = val - VAL_W'(1);
        if (neg || val == '0) return '0;
        else if (v > VAL_W'(lim) - VAL_W'(1)) return COL_W'(lim - (COL_W+1)'(1));
        else return COL_W'(v);
    endfunction

    assign w_cur_addr = f_addr(r_crow, r_ccol, r_top);
    assign w_row_end  = f_addr(r_crow, COL_W'(COLUMNS - 1), r_top);
    assign w_top_base = f_addr('0, '0, r_top);
    assign w_cur      = r_csi[r_pi[CI_W-1:0]];

    assign o_res_valid = r_ov;
    assign o_res       = r_out;
    assign o_init      = (r_state == ST_SWEEP) && !r_sw_emit;

    always_comb begin
        t_res              v_res;
        logic              v_emit, v_adv, v_clr, v_print, v_done;
        logic [CHAR_W-1:0] v_b;
        logic [13:0]       v_mul;

        n_state = r_state;  n_top = r_top;    n_crow = r_crow;  n_ccol = r_ccol;
        n_pcol = r_pcol;    n_attr = r_attr;  n_phase = r_phase; n_kind = r_kind;
        n_clen = r_clen;    n_pi = r_pi;      n_tlen = r_tlen;  n_font = r_font;
        n_ov = r_ov && !i_pop;
        n_out = r_out;      n_pend = r_pend;
        n_sw_addr = r_sw_addr; n_sw_last = r_sw_last; n_sw_emit = r_sw_emit;
        n_rd_ok = r_rd_ok;  n_pstage = r_pstage; n_neg = r_neg; n_ptgt = r_ptgt;
        n_val = r_val;
        o_q_take = 1'b0;
        w_we = 1'b0; w_wa = w_cur_addr; w_wd = '0; w_ra = '0; w_csi_we = 1'b0;
        v_res = '0; v_emit = 1'b0; v_adv = 1'b0; v_clr = 1'b0; v_print = 1'b0;
        v_done = 1'b0;
        v_b = i_q_entry.item.char_byte;
        v_mul = 14'(r_val) * 14'd10 + 14'(w_cur[3:0]);

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && (!r_ov || i_pop)) begin
                    o_q_take = 1'b1;
                    v_emit   = 1'b1;
                    case (i_q_entry.cls)
                        CLS_READ: begin
                            v_res.event_res = EV_READ;
                            v_res.cell_row  = i_q_entry.item.read_row;
                            v_res.cell_col  = i_q_entry.item.read_col;
                            n_rd_ok = ({1'b0, i_q_entry.item.read_row} < (ROW_W+1)'(ROWS)) &&
                                      ({1'b0, i_q_entry.item.read_col} < (COL_W+1)'(COLUMNS));
                            if (n_rd_ok) begin
                                w_ra = f_addr(i_q_entry.item.read_row,
                                              i_q_entry.item.read_col, r_top);
                            end
                            v_emit  = 1'b0;
                            n_state = ST_READ;
                        end
                        CLS_FONT: begin
                            n_font = ~r_font;
                            v_res.event_res = EV_MODE;
                        end
                        CLS_CR: begin
                            v_res.event_res = EV_NONE;
                        end
                        CLS_LF: begin
                            v_res.event_res = EV_NEWLINE;
                            v_adv = 1'b1;
                        end
                        CLS_BS: begin
                            if (r_ccol != '0) begin
                                n_ccol = r_ccol - COL_W'(1);
                            end else if (r_crow != '0) begin
                                n_crow = r_crow - ROW_W'(1);
                                n_ccol = COL_W'(COLUMNS - 1);
                            end
                        end
                        CLS_SUB: begin
                            v_clr = 1'b1;
                        end
                        CLS_BEL: begin
                            v_res.event_res = EV_BELL;
                        end
                        CLS_ESC: begin
                            n_phase = PH_ESC;
                            n_kind  = KD_PLAIN;
                            n_clen  = '0;
                            n_tlen  = '0;
                            n_attr  = ATTR_NORMAL;
                        end
                        default: begin
                            if (r_phase == PH_IDLE) begin
                                v_print = 1'b1;
                            end else if (r_phase == PH_ESC) begin
                                n_phase = PH_BODY;
                                if (v_b == CH_B) n_attr = ATTR_ACCENT;
                                else if (v_b == CH_LBRK) n_kind = KD_CSI;
                                else if (v_b == CH_DOLR) begin
                                    n_kind = KD_TUNE;
                                    n_tlen = '0;
                                end else n_attr = ATTR_NORMAL;
                            end else if (r_kind == KD_TUNE) begin
                                if (v_b == CH_BANG || r_tlen >= TL_W'(TUNE_MAX)) begin
                                    n_phase = PH_IDLE;
                                    v_res.event_res = EV_TUNE_END;
                                end else begin
                                    n_tlen = r_tlen + TL_W'(1);
                                    v_res.event_res = EV_TUNE;
                                    v_res.cell_char = v_b;
                                end
                            end else if (r_kind == KD_CSI) begin
                                if (v_b inside {[CH_A:CH_Z_LC]}) begin
                                    n_phase = PH_IDLE;
                                    if (r_clen == '0 && v_b == CH_K) begin
                                        // Erase to row end runs as a sweep.
                                        v_res.event_res = EV_ERASED;
                                        v_res.cell_row  = r_crow;
                                        v_res.cell_col  = r_ccol;
                                        n_sw_addr = w_cur_addr;
                                        n_sw_last = w_row_end;
                                        n_sw_emit = 1'b1;
                                        n_state   = ST_SWEEP;
                                        v_emit    = 1'b0;
                                    end else if (r_clen == '0 && v_b == CH_H) begin
                                        n_crow = '0;
                                        n_ccol = '0;
                                        v_res.event_res = EV_CURSOR;
                                    end else if (r_clen == CL_W'(1) && v_b == CH_J &&
                                                 r_csi[0] == CH_2) begin
                                        v_clr = 1'b1;
                                    end else if (r_clen >= CL_W'(2) && v_b == CH_H) begin
                                        v_res.event_res = EV_CURSOR;
                                        n_pi    = '0;
                                        n_state = ST_SEMI;
                                        v_emit  = 1'b0;
                                    end else begin
                                        v_print = 1'b1;
                                    end
                                end else if (r_clen < CL_W'(CSI_MAX)) begin
                                    w_csi_we = 1'b1;
                                    n_clen   = r_clen + CL_W'(1);
                                end
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    endcase

                    if (v_print) begin
                        w_we = 1'b1;
                        w_wa = w_cur_addr;
                        w_wd = {r_attr, v_b};
                        v_res.event_res = EV_CELL;
                        v_res.cell_row  = r_crow;
                        v_res.cell_col  = r_ccol;
                        v_res.cell_char = v_b;
                        v_res.cell_attr = r_attr;
                        if (r_ccol == COL_W'(COLUMNS - 1)) v_adv = 1'b1;
                        else n_ccol = r_ccol + COL_W'(1);
                    end

                    if (v_adv) begin
                        n_ccol = '0;
                        if (r_crow == ROW_W'(ROWS - 1)) begin
                            // The top row is cleared and becomes the new bottom row.
                            v_res.scrolled = 1'b1;
                            n_top = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                            n_sw_addr = w_top_base;
                            n_sw_last = w_top_base + AW'(COLUMNS - 1);
                            n_sw_emit = 1'b1;
                            n_state   = ST_SWEEP;
                            v_emit    = 1'b0;
                        end else begin
                            n_crow = r_crow + ROW_W'(1);
                        end
                    end

                    if (v_clr) begin
                        v_res.event_res = EV_CLEARED;
                        n_attr = ATTR_NORMAL;
                        n_top  = '0;
                        n_crow = '0;
                        n_ccol = '0;
                        n_sw_addr = '0;
                        n_sw_last = AW'(DEPTH - 1);
                        n_sw_emit = 1'b1;
                        n_state   = ST_SWEEP;
                        v_emit    = 1'b0;
                    end

                    v_res.cursor_row_out = n_crow;
                    v_res.cursor_col_out = n_ccol;
                    v_res.narrow_font    = n_font;
                    if (v_emit) begin
                        n_out = v_res;
                        n_ov  = 1'b1;
                    end else begin
                        n_pend = v_res;
                    end
                end
            end
            ST_SWEEP: begin
                w_we = 1'b1;
                w_wa = r_sw_addr;
                w_wd = '0;
                if (r_sw_addr == r_sw_last) begin
                    if (r_sw_emit) begin
                        n_out = r_pend;
                        n_ov  = 1'b1;
                    end
                    n_state = ST_IDLE;
                end else begin
                    n_sw_addr = r_sw_addr + AW'(1);
                end
            end
            ST_READ: begin
                v_res = r_pend;
                if (r_rd_ok) begin
                    v_res.cell_char = r_rd[CHAR_W-1:0];
                    v_res.cell_attr = r_rd[CELL_W-1:CHAR_W];
                end
                n_out   = v_res;
                n_ov    = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SEMI: begin
                if (r_pi < r_clen && w_cur != CH_SEMI) begin
                    n_pi = r_pi + CL_W'(1);
                end else begin
                    if (r_pi < r_clen) begin
                        n_pi   = r_pi + CL_W'(1);
                        n_ptgt = 1'b0;
                    end else begin
                        n_pi   = '0;
                        n_pcol = '0;
                        n_ptgt = 1'b1;
                    end
                    n_pstage = 1'b0;
                    n_neg    = 1'b0;
                    n_val    = '0;
                    n_state  = ST_NUM;
                end
            end
            ST_NUM: begin
                if (r_pi >= r_clen) begin
                    v_done = 1'b1;
                end else if (!r_pstage) begin
                    if (w_cur == CH_SP || w_cur inside {[CH_TAB:CH_LAST_WS]}) begin
                        n_pi = r_pi + CL_W'(1);
                    end else if (w_cur == CH_PLUS || w_cur == CH_MINUS) begin
                        n_neg    = (w_cur == CH_MINUS);
                        n_pi     = r_pi + CL_W'(1);
                        n_pstage = 1'b1;
                    end else begin
                        n_pstage = 1'b1;
                    end
                end else if (w_cur inside {[CH_0:CH_9]}) begin
                    n_val = (v_mul > 14'(NUM_CAP)) ? NUM_CAP : v_mul[VAL_W-1:0];
                    n_pi  = r_pi + CL_W'(1);
                end else begin
                    v_done = 1'b1;
                end

                if (v_done) begin
                    if (!r_ptgt) begin
                        // Column field done; the row field is parsed from the start.
                        n_pcol   = f_pos(r_neg, r_val, (COL_W+1)'(COLUMNS));
                        n_ptgt   = 1'b1;
                        n_pi     = '0;
                        n_pstage = 1'b0;
                        n_neg    = 1'b0;
                        n_val    = '0;
                    end else begin
                        n_crow = ROW_W'(f_pos(r_neg, r_val, (COL_W+1)'(ROWS)));
                        n_ccol = r_pcol;
                        v_res  = r_pend;
                        v_res.cursor_row_out = n_crow;
                        v_res.cursor_col_out = n_ccol;
                        n_out   = v_res;
                        n_ov    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rd <= mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_csi_we) r_csi[r_clen[CI_W-1:0]] <= i_q_entry.item.char_byte;
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_pend   <= n_pend;
        r_pcol   <= n_pcol;
        r_pi     <= n_pi;
        r_rd_ok  <= n_rd_ok;
        r_pstage <= n_pstage;
        r_neg    <= n_neg;
        r_ptgt   <= n_ptgt;
        r_val    <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_top     <= '0;
            r_crow    <= '0;
            r_ccol    <= '0;
            r_attr    <= ATTR_NORMAL;
            r_phase   <= PH_IDLE;
            r_kind    <= KD_PLAIN;
            r_clen    <= '0;
            r_tlen    <= '0;
            r_font    <= FONT_RESET;
            r_ov      <= 1'b0;
            r_sw_addr <= '0;
            r_sw_last <= AW'(DEPTH - 1);
            r_sw_emit <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_crow    <= n_crow;
            r_ccol    <= n_ccol;
            r_attr    <= n_attr;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_clen    <= n_clen;
            r_tlen    <= n_tlen;
            r_font    <= n_font;
            r_ov      <= n_ov;
            r_sw_addr <= n_sw_addr;
            r_sw_last <= n_sw_last;
            r_sw_emit <= n_sw_emit;
        end
    end

endmodule

/* design/text_console_escape_engine_unit.sv */
// Top level of the text console escape engine.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------
//   input    | in        | push / full          | i_item   (t_item)
//   result   | out       | empty / pop          | o_result (t_res)
//
// An ordinary byte passes the queue stage and then the execute step; a
// cell read also passes the read state because the cell memory read is registered.
// A scroll adds a memory sweep over one row, an erase to row end a sweep
// from the cursor to the row end, a clear a sweep over the whole cell
// memory, and a CSI position a serial parse of the stored parameter bytes.
// After reset a clearing pass zeroes the whole cell memory;
// full stays high meanwhile. One result waits in the output register while
// the next item is taken into the queue.
`timescale 1ns / 1ps

module text_console_escape_engine_unit import tcee_pkg::*; #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 40,
    parameter int CSI_MAX  = 16,
    parameter int TUNE_MAX = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_item i_item,
    output logic  empty,
    input  logic  pop,
    output t_res  o_result
);

    logic  w_q_valid, w_q_take, w_init, w_res_valid;
    t_qent w_q_entry;

    tcee_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_hold  (w_init),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .i_take  (w_q_take)
    );

    tcee_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .CSI_MAX  (CSI_MAX),
        .TUNE_MAX (TUNE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_take    (w_q_take),
        .o_init      (w_init),
        .o_res_valid (w_res_valid),
        .o_res       (o_result),
        .i_pop       (pop)
    );

    assign empty = !w_res_valid;

endmodule

/* design/tcee_checker.sv */
// Port-level checks on the text console escape engine and their binding.
`timescale 1ns / 1ps

module tcee_checker import tcee_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 40
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic empty,
    input logic pop,
    input t_res o_result
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> empty)
        else $error("result pending right after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.event_res <= EV_READ))
        else $error("event code out of range");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (int'(o_result.cursor_row_out) < ROWS &&
                    int'(o_result.cursor_col_out) < COLUMNS))
        else $error("cursor outside the grid");

    a_scroll_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.scrolled) |->
            (o_result.event_res == EV_CELL || o_result.event_res == EV_NEWLINE))
        else $error("scroll reported with an unrelated event");

endmodule

bind text_console_escape_engine_unit tcee_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcee_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
